[src/ubxd_pkg.sv]
// Shared types, codes and constants of the binary frame deframer.
package ubxd_pkg;

    localparam int unsigned MAX_PAYLOAD = 512;
    localparam int unsigned LIMIT_W = 16;

    localparam logic [7:0] SYNC_FIRST = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [9:0] MAX_LEN_RESET = 10'd400;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] frame_class;
        logic [7:0] msg_id;
        logic [8:0] offset;
        logic [9:0] length;
    } result_t;

endpackage

[src/ubx_frame_deframer.sv]
// Top level of the binary frame deframer with configuration register.
// The input channel takes one received serial byte per beat (in_valid, in_stall,
// rx_byte). The output channel delivers at most one result per input beat: a
// payload byte with its offset, or a frame end that reports whether the two
// Fletcher check bytes matched. Bytes outside a frame, header bytes and check
// byte A produce no result.
// A byte is taken every cycle while the skid stage is empty. A result is
// registered in the output register, or in the skid stage when the output
// register holds a stalled beat; the parser forms it from its state and the byte.
// When the receiver stalls, the output register holds its beat and one more
// result can be caught in the skid stage; in_stall then rises until the
// output drains.
// Reset returns the parser to the hunt for the first sync byte, empties both
// result stages and sets the payload length limit to 400. The user must write
// it via cfg_write_en/cfg_write_data with no frame in progress; not enforced.
module ubx_frame_deframer
    import ubxd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [9:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] data_byte,
    output logic [7:0] message_class,
    output logic [7:0] message_id,
    output logic [8:0] byte_offset,
    output logic [9:0] frame_length
);

    logic [9:0] max_len_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    out_res;
    logic       skid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    assign in_stall = skid_full;
    assign accept = in_valid && !skid_full;

    ubxd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ubxd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .full      (skid_full)
    );

    assign result_kind = out_res.kind;
    assign data_byte = out_res.data;
    assign message_class = out_res.frame_class;
    assign message_id = out_res.msg_id;
    assign byte_offset = out_res.offset;
    assign frame_length = out_res.length;

endmodule

[src/ubxd_parser.sv]
// Byte-level frame parser: sync hunt, header capture, Fletcher sums and check.
module ubxd_parser
    import ubxd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic [9:0]    max_len,
    output logic          res_valid,
    output result_t       res
);

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [9:0]  decl_len_reg, decl_len_next;
    logic [9:0]  count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  ck_a_reg, ck_a_next;

    logic [7:0]         add_a;
    logic [7:0]         add_b;
    logic [9:0]         count_inc;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] frame_len;

    assign add_a = sum_a_reg + rx_byte;
    assign add_b = sum_b_reg + add_a;
    assign count_inc = count_reg + 10'd1;
    assign frame_len = {rx_byte, len_lo_reg};

    always_comb
    begin
        if (LIMIT_W'(max_len) > LIMIT_W'(MAX_PAYLOAD))
        begin
            limit = LIMIT_W'(MAX_PAYLOAD);
        end
        else
        begin
            limit = LIMIT_W'(max_len);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next = id_reg;
        len_lo_next = len_lo_reg;
        decl_len_next = decl_len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next = ck_a_reg;
        res_valid = 1'b0;
        res.kind = KIND_PAYLOAD;
        res.data = 8'd0;
        res.frame_class = class_reg;
        res.msg_id = id_reg;
        res.offset = 9'd0;
        res.length = decl_len_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                        count_next = 10'd0;
                        phase_next = PH_CLASS;
                    end
                    else if (rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CLASS:
                begin
                    class_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_lo_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    if (frame_len > limit)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        decl_len_next = frame_len[9:0];
                        count_next = 10'd0;
                        phase_next = (frame_len == '0) ? PH_CK_A : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    res_valid = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.data = rx_byte;
                    res.offset = count_reg[8:0];
                    count_next = count_inc;
                    if (count_inc >= decl_len_reg)
                    begin
                        phase_next = PH_CK_A;
                    end
                end
                PH_CK_A:
                begin
                    ck_a_next = rx_byte;
                    phase_next = PH_CK_B;
                end
                PH_CK_B:
                begin
                    res_valid = 1'b1;
                    res.kind = (sum_a_reg == ck_a_reg && sum_b_reg == rx_byte) ?
                               KIND_GOOD : KIND_BAD;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            class_reg <= 8'd0;
            id_reg <= 8'd0;
            len_lo_reg <= 8'd0;
            decl_len_reg <= 10'd0;
            count_reg <= 10'd0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
            ck_a_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg <= id_next;
            len_lo_reg <= len_lo_next;
            decl_len_reg <= decl_len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            ck_a_reg <= ck_a_next;
        end
    end

endmodule

[src/ubxd_skid.sv]
// Result output register with a one-entry skid stage behind it.
module ubxd_skid
    import ubxd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_res,
    output logic    full
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_res_reg, skid_res_next;
    logic    out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next = skid_res_reg;
        if (skid_valid_reg && out_take)
        begin
            out_res_next = skid_res_reg;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_res_next = push_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next = push_res;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;
    assign full = skid_valid_reg;

endmodule

[src/ubxd_checker.sv]
// Port-level checks of the deframer and the bind that attaches them.
module ubxd_checker
    import ubxd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_kind,
    input logic [7:0] data_byte,
    input logic [8:0] byte_offset,
    input logic [9:0] frame_length
);

    // A stalled result beat stays and keeps its kind.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind))
        else $error("stalled result beat was dropped or changed");

    // The input side is only held off while a result waits at the output.
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_PAYLOAD || result_kind == KIND_GOOD ||
                       result_kind == KIND_BAD))
        else $error("illegal result kind");

    a_frame_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_PAYLOAD |-> data_byte == 8'd0 &&
                                                     byte_offset == 9'd0)
        else $error("frame end beat carries payload data");

    a_offset_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_PAYLOAD |-> {1'b0, byte_offset} < frame_length)
        else $error("payload offset beyond declared length");

endmodule

bind ubx_frame_deframer ubxd_checker u_ubxd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .byte_offset  (byte_offset),
    .frame_length (frame_length)
);
